### hdl/iff_pkg.sv
// ----------------------------------------------------------------------------
// iff_pkg
// Shared types, codes and character helpers for the integer field formatter.
// ----------------------------------------------------------------------------
package iff_pkg;

  localparam int NUM_DIGITS = 22;
  localparam int DIG_IDX_W  = 5;
  localparam int CNT_W      = 8;
  localparam int VALUE_W    = 64;

  localparam logic [2:0] CONV_DEC   = 3'd0;
  localparam logic [2:0] CONV_UNS   = 3'd1;
  localparam logic [2:0] CONV_OCT   = 3'd2;
  localparam logic [2:0] CONV_HEXL  = 3'd3;
  localparam logic [2:0] CONV_HEXU  = 3'd4;
  localparam logic [2:0] CONV_PTR   = 3'd5;

  localparam logic [1:0] SIZE_INT   = 2'd0;
  localparam logic [1:0] SIZE_SHORT = 2'd1;

  localparam logic [1:0] SIGN_SPACE = 2'd1;
  localparam logic [1:0] SIGN_PLUS  = 2'd2;

  localparam logic [2:0] REG_CONVERSION = 3'd0;
  localparam logic [2:0] REG_VALUE_SIZE = 3'd1;
  localparam logic [2:0] REG_SIGN_MODE  = 3'd2;
  localparam logic [2:0] REG_LEFT_JUST  = 3'd3;
  localparam logic [2:0] REG_ALT_FORM   = 3'd4;
  localparam logic [2:0] REG_ZERO_PAD   = 3'd5;
  localparam logic [2:0] REG_FIELD_W    = 3'd6;
  localparam logic [2:0] REG_MIN_DIGITS = 3'd7;

  typedef struct packed {
    logic load;
    logic step;
    logic measure;
    logic layout;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_dec;
    logic last;
    logic out_free;
  } status_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'd0, d};
    end else if (upper) begin
      c = 8'h37 + {4'd0, d};
    end else begin
      c = 8'h57 + {4'd0, d};
    end
    return c;
  endfunction

  function automatic logic [7:0] nil_char(input logic [2:0] i);
    logic [7:0] c;
    unique case (i)
      3'd0:    c = 8'h28;
      3'd1:    c = 8'h6E;
      3'd2:    c = 8'h69;
      3'd3:    c = 8'h6C;
      default: c = 8'h29;
    endcase
    return c;
  endfunction

endpackage

### hdl/integer_field_formatter.sv
// ----------------------------------------------------------------------------
// integer_field_formatter
// Formats one integer word as printf-style text, one character per word out.
// Sequence: load; decimal and unsigned values then run a 64-step
// binary-to-BCD shift loop that produces the digits; measure; layout; emit.
// Throughput: one character per cycle while the output does not stall; a new
// word is taken only after the last character of its field is issued.
// Reset: synchronous; resets the sequencer, config and out_valid; idles.
// ----------------------------------------------------------------------------
module integer_field_formatter #(
  parameter int MAX_FIELD = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        last_char
);
  import iff_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  iff_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  iff_datapath #(
    .MAX_FIELD (MAX_FIELD)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .value     (value),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_char  (out_char),
    .last_char (last_char)
  );

  // An accepted word keeps the block busy until its field has been emitted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while idle did not make the block busy");

  // While idle, any word still held at the output must close a field.
  a_idle_only_after_last: assert property (@(posedge clk) disable iff (rst)
    !in_stall && out_valid |-> last_char)
    else $error("block idle with an unfinished field at the output");

  // Characters are issued only in the emit phase.
  a_emit_only_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free && in_stall)
    else $error("character issued while output busy or idle");

endmodule

### hdl/iff_datapath.sv
// ----------------------------------------------------------------------------
// iff_datapath
// Configuration registers, digit extraction, field layout and output register.
// ----------------------------------------------------------------------------
module iff_datapath #(
  parameter int MAX_FIELD = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [2:0]       cfg_index,
  input  logic [6:0]       cfg_data,
  input  logic [63:0]      value,
  input  iff_pkg::cmd_t    cmd,
  output iff_pkg::status_t status,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [7:0]       out_char,
  output logic             last_char
);
  import iff_pkg::*;

  logic [2:0] conversion;
  logic [1:0] value_size;
  logic [1:0] sign_mode;
  logic       left_justify;
  logic       alternate_form;
  logic       zero_pad;
  logic [6:0] field_width;
  logic [6:0] min_digits;

  logic [2:0]  conv_eff;
  logic [2:0]  conv;
  logic        neg;
  logic        nil;
  logic        nonzero;
  logic [63:0] sh;
  logic [3:0]  dig [NUM_DIGITS];
  logic [3:0]  dig_next [NUM_DIGITS];
  logic [DIG_IDX_W-1:0] ndig;
  logic [6:0]  zeros;
  logic [1:0]  npre;
  logic [7:0]  pre0, pre1;
  logic [CNT_W-1:0] e1, e2, e4, e5, limit, pos;

  logic [63:0] masked, sext, mag_in;
  logic        neg_in;
  logic [87:0] wide;
  logic [3:0]  adj [NUM_DIGITS];
  logic [DIG_IDX_W-1:0] ndig_c;
  logic        prec_given;
  logic [6:0]  prec;
  logic [6:0]  zeros_c;
  logic [1:0]  npre_c;
  logic [7:0]  pre0_c, pre1_c;
  logic [CNT_W-1:0] body, pad, lead, zpad, trail, total, e1c, e2c, e3c, e4c, e5c;
  logic        zp;
  logic [CNT_W-1:0] di;
  logic [7:0]  ch;
  logic        out_free;

  assign conv_eff   = (conversion >= 3'd6) ? CONV_UNS : conversion;
  assign prec_given = ~min_digits[6];
  assign prec       = prec_given ? min_digits : 7'd1;
  assign zp         = ~left_justify & zero_pad & ~prec_given;
  assign out_free   = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      conversion     <= CONV_DEC;
      value_size     <= SIZE_INT;
      sign_mode      <= 2'd0;
      left_justify   <= 1'b0;
      alternate_form <= 1'b0;
      zero_pad       <= 1'b0;
      field_width    <= 7'd0;
      min_digits     <= 7'h7F;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CONVERSION: conversion     <= cfg_data[2:0];
        REG_VALUE_SIZE: value_size     <= cfg_data[1:0];
        REG_SIGN_MODE:  sign_mode      <= cfg_data[1:0];
        REG_LEFT_JUST:  left_justify   <= cfg_data[0];
        REG_ALT_FORM:   alternate_form <= cfg_data[0];
        REG_ZERO_PAD:   zero_pad       <= cfg_data[0];
        REG_FIELD_W:    field_width    <= cfg_data;
        default:        min_digits     <= cfg_data;
      endcase
    end
  end

  // Size the raw word and take the magnitude of a negative signed value.
  always_comb begin
    unique case (value_size)
      SIZE_INT: begin
        masked = {32'd0, value[31:0]};
        sext   = {{32{value[31]}}, value[31:0]};
        neg_in = value[31];
      end
      SIZE_SHORT: begin
        masked = {48'd0, value[15:0]};
        sext   = {{48{value[15]}}, value[15:0]};
        neg_in = value[15];
      end
      default: begin
        masked = value;
        sext   = value;
        neg_in = value[63];
      end
    endcase
    if (conv_eff == CONV_PTR) masked = value;
    if (conv_eff != CONV_DEC) neg_in = 1'b0;
    mag_in = neg_in ? (64'd0 - sext) : masked;
    wide   = {24'd0, mag_in};
  end

  // One double-dabble step: add three to digits of five or more, then shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (dig[i] >= 4'd5) ? dig[i] + 4'd3 : dig[i];
    end
    dig_next[0] = {adj[0][2:0], sh[63]};
    for (int i = 1; i < NUM_DIGITS; i++) begin
      dig_next[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  always_comb begin
    ndig_c = DIG_IDX_W'(1);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (dig[i] != 4'd0) ndig_c = DIG_IDX_W'(i + 1);
    end
    zeros_c = (prec > {2'd0, ndig_c}) ? prec - {2'd0, ndig_c} : 7'd0;
    if (conv == CONV_OCT && alternate_form && zeros_c == 7'd0 && nonzero) zeros_c = 7'd1;
    npre_c = 2'd0;
    pre0_c = 8'h30;
    pre1_c = 8'h78;
    if (conv == CONV_DEC) begin
      if (neg) begin
        npre_c = 2'd1;
        pre0_c = 8'h2D;
      end else if (sign_mode == SIGN_SPACE) begin
        npre_c = 2'd1;
        pre0_c = 8'h20;
      end else if (sign_mode == SIGN_PLUS) begin
        npre_c = 2'd1;
        pre0_c = 8'h2B;
      end
    end
    if ((conv == CONV_HEXL || conv == CONV_HEXU) && alternate_form && nonzero) begin
      npre_c = 2'd2;
      if (conv == CONV_HEXU) pre1_c = 8'h58;
    end
    if (conv == CONV_PTR) npre_c = 2'd2;
  end

  always_comb begin
    body  = {6'd0, npre} + {1'd0, zeros} + {3'd0, ndig};
    pad   = ({1'd0, field_width} > body) ? {1'd0, field_width} - body : '0;
    lead  = (~left_justify & ~zp) ? pad : '0;
    zpad  = zp ? pad : '0;
    trail = left_justify ? pad : '0;
    e1c   = lead;
    e2c   = e1c + {6'd0, npre};
    e3c   = e2c + zpad;
    e4c   = e3c + {1'd0, zeros};
    e5c   = e4c + {3'd0, ndig};
    total = nil ? CNT_W'(5) : e5c + trail;
  end

  // Zero padding and leading zeros form one run of '0' from e2 up to e4.
  always_comb begin
    di = e5 - pos - CNT_W'(1);
    if (nil) begin
      ch = nil_char(pos[2:0]);
    end else if (pos < e1) begin
      ch = 8'h20;
    end else if (pos < e2) begin
      ch = (pos == e1) ? pre0 : pre1;
    end else if (pos < e4) begin
      ch = 8'h30;
    end else if (pos < e5) begin
      ch = digit_char(dig[di[DIG_IDX_W-1:0]], conv == CONV_HEXU);
    end else begin
      ch = 8'h20;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      conv    <= conv_eff;
      neg     <= neg_in;
      nil     <= (conv_eff == CONV_PTR) && (value == 64'd0);
      nonzero <= mag_in != 64'd0;
      sh      <= mag_in;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        if (conv_eff == CONV_OCT) begin
          dig[i] <= {1'b0, wide[3*i +: 3]};
        end else if (conv_eff == CONV_DEC || conv_eff == CONV_UNS) begin
          dig[i] <= 4'd0;
        end else begin
          dig[i] <= wide[4*i +: 4];
        end
      end
    end else if (cmd.step) begin
      sh <= {sh[62:0], 1'b0};
      for (int i = 0; i < NUM_DIGITS; i++) dig[i] <= dig_next[i];
    end
    if (cmd.measure) begin
      ndig  <= ndig_c;
      zeros <= zeros_c;
      npre  <= npre_c;
      pre0  <= pre0_c;
      pre1  <= pre1_c;
    end
    if (cmd.layout) begin
      e1    <= e1c;
      e2    <= e2c;
      e4    <= e4c;
      e5    <= e5c;
      limit <= (total > CNT_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : total;
      pos   <= '0;
    end else if (cmd.emit) begin
      pos <= pos + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char  <= ch;
      last_char <= (pos + CNT_W'(1)) == limit;
    end
  end

  assign status.is_dec   = (conv_eff == CONV_DEC) || (conv_eff == CONV_UNS);
  assign status.last     = (pos + CNT_W'(1)) == limit;
  assign status.out_free = out_free;

endmodule

### hdl/iff_ctrl.sv
// ----------------------------------------------------------------------------
// iff_ctrl
// Sequencer: accept, decimal conversion steps, measure, layout and emission.
// ----------------------------------------------------------------------------
module iff_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  iff_pkg::status_t status,
  output iff_pkg::cmd_t    cmd
);
  import iff_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CONV   = 3'd1;
  localparam logic [2:0] ST_MEAS   = 3'd2;
  localparam logic [2:0] ST_LAYOUT = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0] state, state_next;
  logic [5:0] step_cnt;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.is_dec ? ST_CONV : ST_MEAS;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (step_cnt == 6'd63) state_next = ST_MEAS;
      end
      ST_MEAS: begin
        cmd.measure = 1'b1;
        state_next  = ST_LAYOUT;
      end
      ST_LAYOUT: begin
        cmd.layout = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
        if (status.out_free && status.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= 6'd0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        step_cnt <= 6'd0;
      end else if (cmd.step) begin
        step_cnt <= step_cnt + 6'd1;
      end
    end
  end

  assign in_stall = state != ST_IDLE;

endmodule
